@@ hdl/owfd_pkg.sv @@
`default_nettype none

package owfd_pkg;

    localparam int FRAME_BITS_DEFAULT = 40;
    localparam int RAW_BITS           = 40;
    localparam int WIDTH_BITS         = 16;
    localparam int TOL_BITS           = 7;
    localparam int PRE_BITS           = 8;
    localparam int CMP_BITS           = 24;
    localparam int CFG_INDEX_BITS     = 4;
    localparam int CFG_DATA_BITS      = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_WIDTH  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PREAMBLE    = 4'd3;

    localparam logic [WIDTH_BITS-1:0] SHORT_WIDTH_RESET = 16'd500;
    localparam logic [WIDTH_BITS-1:0] LONG_WIDTH_RESET  = 16'd1500;
    localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET   = 7'd20;
    localparam logic [PRE_BITS-1:0]   PREAMBLE_RESET    = 8'd8;

    localparam logic [WIDTH_BITS-1:0] PULSE_INDEX_MAX = 16'hFFFF;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ZERO,
        CLS_ONE
    } cls_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] pulse_width;
        logic                  last_pulse;
    } in_word_t;

    typedef struct packed {
        logic                    status;
        logic [7:0]              device_id;
        logic [2:0]              channel;
        logic                    batt_flag;
        logic signed [11:0]      temperature;
        logic [7:0]              humidity;
        logic [RAW_BITS-1:0]     raw_code;
    } out_word_t;

    typedef struct packed {
        cls_t cls;
        logic last_pulse;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

@@ hdl/owfd_front.sv @@
`default_nettype none

module owfd_front (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [owfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [owfd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  owfd_pkg::in_word_t                   in_data,
    input  owfd_pkg::q_status_t                  q_status,
    output logic                                 q_push,
    output owfd_pkg::q_entry_t                   q_wdata,
    output logic [owfd_pkg::PRE_BITS-1:0]        preamble
);

    localparam int WB = owfd_pkg::WIDTH_BITS;
    localparam int CB = owfd_pkg::CMP_BITS;

    logic [WB-1:0]                 short_width_reg;
    logic [WB-1:0]                 long_width_reg;
    logic [owfd_pkg::TOL_BITS-1:0] tolerance_reg;
    logic [owfd_pkg::PRE_BITS-1:0] preamble_reg;
    logic                          settle_reg;
    logic [CB-1:0]                 prod_short_reg;
    logic [CB-1:0]                 prod_long_reg;
    logic                          cfg_write;
    logic                          hit_long;
    logic                          hit_short;

    // A pulse lies inside a window when 100 * (|w - nominal| + 1) <= nominal * percent,
    // which equals the truncated tolerance test without a divider.
    function automatic logic window_hit(input logic [WB-1:0] w, input logic [WB-1:0] nominal,
                                        input logic [CB-1:0] prod);
        logic [WB-1:0] diff;
        logic [CB-1:0] d1;
        logic [CB-1:0] scaled;
        diff   = (w >= nominal) ? (w - nominal) : (nominal - w);
        d1     = CB'(diff) + CB'(1);
        scaled = (d1 << 6) + (d1 << 5) + (d1 << 2);
        return scaled <= prod;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign preamble  = preamble_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_width_reg <= owfd_pkg::SHORT_WIDTH_RESET;
            long_width_reg  <= owfd_pkg::LONG_WIDTH_RESET;
            tolerance_reg   <= owfd_pkg::TOLERANCE_RESET;
            preamble_reg    <= owfd_pkg::PREAMBLE_RESET;
            settle_reg      <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    owfd_pkg::CFG_SHORT_WIDTH: short_width_reg <= cfg_data;
                    owfd_pkg::CFG_LONG_WIDTH:  long_width_reg  <= cfg_data;
                    owfd_pkg::CFG_TOLERANCE:   tolerance_reg   <= cfg_data[owfd_pkg::TOL_BITS-1:0];
                    owfd_pkg::CFG_PREAMBLE:    preamble_reg    <= cfg_data[owfd_pkg::PRE_BITS-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_short_reg <= CB'(short_width_reg) * CB'(tolerance_reg);
        prod_long_reg  <= CB'(long_width_reg) * CB'(tolerance_reg);
    end

    assign in_stall = q_status.full || settle_reg;
    assign q_push   = in_valid && !in_stall;

    assign hit_long  = window_hit(in_data.pulse_width, long_width_reg, prod_long_reg);
    assign hit_short = window_hit(in_data.pulse_width, short_width_reg, prod_short_reg);

    always_comb
    begin
        q_wdata.last_pulse = in_data.last_pulse;
        if (hit_long)
            q_wdata.cls = owfd_pkg::CLS_ONE;
        else if (hit_short)
            q_wdata.cls = owfd_pkg::CLS_ZERO;
        else
            q_wdata.cls = owfd_pkg::CLS_NONE;
    end

endmodule

`default_nettype wire

@@ hdl/owfd_queue.sv @@
`default_nettype none

module owfd_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  owfd_pkg::q_entry_t   wdata,
    input  wire                  pop,
    output owfd_pkg::q_entry_t   rdata,
    output owfd_pkg::q_status_t  status
);

    localparam int DEPTH    = owfd_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    owfd_pkg::q_entry_t  mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    assign rdata        = mem[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !status.full)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

@@ hdl/owfd_back.sv @@
`default_nettype none

module owfd_back #(
    parameter int FRAME_BITS = owfd_pkg::FRAME_BITS_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  [owfd_pkg::PRE_BITS-1:0]  preamble,
    input  owfd_pkg::q_entry_t             q_rdata,
    input  owfd_pkg::q_status_t            q_status,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire                            out_stall,
    output owfd_pkg::out_word_t            out_data
);

    localparam int WB       = owfd_pkg::WIDTH_BITS;
    localparam int RB       = owfd_pkg::RAW_BITS;
    localparam int CNT_BITS = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_BITS-1:0] FB_COUNT = CNT_BITS'(FRAME_BITS);

    logic [WB-1:0]         pulse_index_reg;
    logic [WB-1:0]         pulse_index_next;
    logic [CNT_BITS-1:0]   bits_taken_reg;
    logic [CNT_BITS-1:0]   bits_taken_next;
    logic [FRAME_BITS-1:0] frame_bits_reg;
    logic [FRAME_BITS-1:0] frame_bits_next;
    logic                  pending_bit_reg;
    logic                  pending_bit_next;
    logic                  pending_valid_reg;
    logic                  pending_valid_next;
    logic                  stopped_reg;
    logic                  stopped_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    owfd_pkg::out_word_t   out_data_reg;
    owfd_pkg::out_word_t   out_data_next;

    logic [CNT_BITS-1:0]   bits_upd;
    logic [FRAME_BITS-1:0] frame_upd;
    logic                  data_slot;
    logic [RB-1:0]         raw_code;
    owfd_pkg::out_word_t   result;

    assign q_pop = !q_status.empty && (!q_rdata.last_pulse || !out_valid_reg || !out_stall);

    always_comb
    begin
        bits_upd  = bits_taken_reg;
        frame_upd = frame_bits_reg;
        if (pending_valid_reg && bits_taken_reg < FB_COUNT)
        begin
            frame_upd = {frame_bits_reg[FRAME_BITS-2:0], pending_bit_reg};
            bits_upd  = bits_taken_reg + 1'b1;
        end
    end

    assign data_slot = (pulse_index_reg != owfd_pkg::PULSE_INDEX_MAX)
                    && (pulse_index_reg >= WB'(preamble))
                    && (pulse_index_reg[0] == preamble[0])
                    && !stopped_reg && (bits_upd < FB_COUNT);

    generate
        if (FRAME_BITS >= RB)
        begin : g_wide
            assign raw_code = frame_upd[FRAME_BITS-1 -: RB];
        end
        else
        begin : g_narrow
            assign raw_code = {frame_upd, {(RB - FRAME_BITS){1'b0}}};
        end
    endgenerate

    always_comb
    begin
        result = '0;
        if (bits_upd < FB_COUNT)
        begin
            result.status = owfd_pkg::STATUS_FAIL;
        end
        else
        begin
            result.status      = owfd_pkg::STATUS_OK;
            result.device_id   = raw_code[39:32];
            result.channel     = {1'b0, raw_code[31:30]} + 3'd1;
            result.batt_flag   = raw_code[29];
            result.temperature = {raw_code[19:16], raw_code[15:8]};
            result.humidity    = raw_code[7:0];
            result.raw_code    = raw_code;
        end
    end

    always_comb
    begin
        pulse_index_next   = pulse_index_reg;
        bits_taken_next    = bits_taken_reg;
        frame_bits_next    = frame_bits_reg;
        pending_bit_next   = pending_bit_reg;
        pending_valid_next = pending_valid_reg;
        stopped_next       = stopped_reg;
        if (q_pop)
        begin
            bits_taken_next    = bits_upd;
            frame_bits_next    = frame_upd;
            pending_valid_next = 1'b0;
            if (data_slot)
            begin
                case (q_rdata.cls)
                    owfd_pkg::CLS_ONE:
                    begin
                        pending_bit_next   = 1'b1;
                        pending_valid_next = 1'b1;
                    end
                    owfd_pkg::CLS_ZERO:
                    begin
                        pending_bit_next   = 1'b0;
                        pending_valid_next = 1'b1;
                    end
                    default:
                    begin
                        stopped_next = 1'b1;
                    end
                endcase
            end
            if (pulse_index_reg != owfd_pkg::PULSE_INDEX_MAX)
                pulse_index_next = pulse_index_reg + 1'b1;
            if (q_rdata.last_pulse)
            begin
                pulse_index_next   = '0;
                bits_taken_next    = '0;
                frame_bits_next    = '0;
                pending_bit_next   = 1'b0;
                pending_valid_next = 1'b0;
                stopped_next       = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (q_pop && q_rdata.last_pulse)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_index_reg   <= '0;
            bits_taken_reg    <= '0;
            frame_bits_reg    <= '0;
            pending_bit_reg   <= 1'b0;
            pending_valid_reg <= 1'b0;
            stopped_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pulse_index_reg   <= pulse_index_next;
            bits_taken_reg    <= bits_taken_next;
            frame_bits_reg    <= frame_bits_next;
            pending_bit_reg   <= pending_bit_next;
            pending_valid_reg <= pending_valid_next;
            stopped_reg       <= stopped_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bits_taken_reg <= FB_COUNT)
        else $error("bit count beyond frame length");

    a_pending_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        pending_valid_reg |-> !stopped_reg)
        else $error("pending bit held after decoding stopped");

    a_train_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_rdata.last_pulse) |=> (pulse_index_reg == '0 && !pending_valid_reg
                                            && out_valid_reg))
        else $error("train state not cleared after last pulse");

endmodule

`default_nettype wire

@@ hdl/ook_pwm_weather_frame_decoder_top.sv @@
// Decodes a pulse-width modulated on-off keyed weather sensor frame of FRAME_BITS bits.
// The input channel takes one word per measured pulse, high and low pulses alternating,
// with last_pulse set on the final pulse of a train. Only that word produces an output
// word: either a fail status or the decoded id, channel, battery flag, temperature,
// humidity and raw 40-bit code.
// Both channels use valid and stall; a word moves when valid is high and stall is low.
// The configuration channel writes one register per valid and ready cycle; ready is
// always high, and the input channel stalls in the cycle after each write while the
// tolerance products are refreshed.
// One input word is taken every cycle while the input channel is not stalled. After the
// last pulse is taken it passes through the two-word queue between the front classifier
// and the frame assembler, and its result is then held in the output register.
// When the receiver stalls, the result stays in the output register while the pulses of
// the next train keep flowing; once that train's last pulse reaches the head of the
// queue, the queue fills and the input channel stalls.
// Reset restores the default configuration, clears the train state and the output valid
// flag, and holds the input stalled while the tolerance products are computed.
`default_nettype none

module ook_pwm_weather_frame_decoder_top #(
    parameter int FRAME_BITS = owfd_pkg::FRAME_BITS_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [owfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [owfd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  owfd_pkg::in_word_t                   in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output owfd_pkg::out_word_t                  out_data
);

    owfd_pkg::q_status_t           q_status;
    owfd_pkg::q_entry_t            q_wdata;
    owfd_pkg::q_entry_t            q_rdata;
    logic                          q_push;
    logic                          q_pop;
    logic [owfd_pkg::PRE_BITS-1:0] preamble;

    owfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .preamble  (preamble)
    );

    owfd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    owfd_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .preamble  (preamble),
        .q_rdata   (q_rdata),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
